>>> rtl/core/dda_line_rasterizer_unit_assert.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked at every rising edge outside reset.
`define DDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Condition that must never be seen outside reset.
`define DDA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define DDA_ASSERT(lbl, prop, msg)
`define DDA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/dda_pkg.sv
// Shared types and constants of the DDA line rasterizer.
`default_nettype none
package dda_pkg;

  // Item kinds carried in the input tuser bit.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  // Frame size registers.
  localparam int unsigned FRAME_W = 12;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 12'd600;

  // Pixel color width.
  localparam int unsigned COLOR_W = 32;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } fsm_e;

  // Commands from the sequencer to the line walker.
  typedef struct packed {
    logic load;
    logic step;
    logic set_slope;
  } walk_ctrl_t;

  // Per-pixel flags from the line walker.
  typedef struct packed {
    logic in_bounds;
    logic last;
  } pix_flags_t;

endpackage
`default_nettype wire

>>> rtl/core/dda_div.sv
// Iterative restoring divider that forms the slope magnitude, one quotient bit per cycle.
`default_nettype none
`include "dda_line_rasterizer_unit_assert.svh"
module dda_div
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] amin_i,
  input  wire logic [COORD_BITS-1:0] amaj_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [FRAC_BITS:0]         quo_o
);

  localparam int unsigned NUM_W = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 2);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [FRAC_BITS:0]    low_q, low_d;
  logic [COORD_BITS-1:0] den_q, den_d;
  logic [FRAC_BITS:0]    quo_q, quo_d;

  logic [NUM_W-1:0]      num;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;

  // Dividend is the minor delta scaled by the fraction, plus half the divisor for rounding.
  assign num = {1'b0, amin_i, {FRAC_BITS{1'b0}}} + NUM_W'(amaj_i >> 1);

  // Shared compare and subtract unit.
  assign trial = {rem_q, low_q[FRAC_BITS]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[COORD_BITS+1];

  // Next state of the iteration.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(FRAC_BITS);
      rem_d  = num[NUM_W-1:FRAC_BITS+1];
      low_d  = num[FRAC_BITS:0];
      den_d  = amaj_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      low_d = {low_q[FRAC_BITS-1:0], 1'b0};
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // A zero major delta only happens for equal endpoints, which have zero slope.
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : quo_q;

  `DDA_ASSERT_NEVER(a_div_start_busy, start_i && busy_q, "divider started while busy")
  `DDA_ASSERT(a_div_done_idle, done_q |-> !busy_q, "divider done while still iterating")

endmodule
`default_nettype wire

>>> rtl/core/dda_walk.sv
// Line walker: latches endpoints, holds the DDA accumulator and forms each pixel.
`default_nettype none
module dda_walk
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire walk_ctrl_t                   ctrl_i,
  input  wire logic signed [COORD_BITS-1:0] x_start_i,
  input  wire logic signed [COORD_BITS-1:0] y_start_i,
  input  wire logic signed [COORD_BITS-1:0] x_end_i,
  input  wire logic signed [COORD_BITS-1:0] y_end_i,
  input  wire logic [COLOR_W-1:0]           color_i,
  input  wire logic [FRAME_W-1:0]           frame_width_i,
  input  wire logic [FRAME_W-1:0]           frame_height_i,
  input  wire logic [FRAC_BITS:0]           quo_i,
  output logic [COORD_BITS-1:0]             amin_o,
  output logic [COORD_BITS-1:0]             amaj_o,
  output logic                              active_o,
  output logic signed [COORD_BITS-1:0]      pix_x_o,
  output logic signed [COORD_BITS-1:0]      pix_y_o,
  output logic [COLOR_W-1:0]                pix_color_o,
  output pix_flags_t                        flags_o
);

  localparam int unsigned DIF_W  = COORD_BITS + 1;
  localparam int unsigned ACC_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned STEP_W = FRAC_BITS + 2;
  localparam int unsigned RND_W  = COORD_BITS + 2;
  localparam int unsigned CMP_W  = ((RND_W > FRAME_W) ? RND_W : FRAME_W) + 1;

  logic                         active_q, active_d;
  logic                         steep_q, steep_d;
  logic signed [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic signed [COORD_BITS-1:0] major_end_q, major_end_d;
  logic                         major_down_q, major_down_d;
  logic                         minor_neg_q, minor_neg_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic signed [STEP_W-1:0]     step_q, step_d;
  logic [COLOR_W-1:0]           color_q, color_d;

  logic [DIF_W-1:0]             dx, dy, adx_full, ady_full;
  logic [COORD_BITS-1:0]        adx, ady;
  logic                         steep_new;
  logic signed [COORD_BITS-1:0] minor0;
  logic [STEP_W-1:0]            mag;

  logic                         acc_neg;
  logic [ACC_W-1:0]             acc_mag;
  logic [ACC_W:0]               rnd_sum;
  logic [RND_W-1:0]             rnd_abs;
  logic [RND_W-1:0]             rnd;
  logic [RND_W-1:0]             px_w, py_w;
  logic [CMP_W-1:0]             px_c, py_c, fw_c, fh_c;
  logic                         last;

  // Endpoint deltas and their magnitudes.
  assign dx       = {x_end_i[COORD_BITS-1], x_end_i} - {x_start_i[COORD_BITS-1], x_start_i};
  assign dy       = {y_end_i[COORD_BITS-1], y_end_i} - {y_start_i[COORD_BITS-1], y_start_i};
  assign adx_full = dx[DIF_W-1] ? (~dx + 1'b1) : dx;
  assign ady_full = dy[DIF_W-1] ? (~dy + 1'b1) : dy;
  assign adx      = adx_full[COORD_BITS-1:0];
  assign ady      = ady_full[COORD_BITS-1:0];

  // Major axis is y only when it has strictly the larger travel.
  assign steep_new = ady > adx;
  assign minor0    = steep_new ? x_start_i : y_start_i;
  assign amaj_o    = steep_new ? ady : adx;
  assign amin_o    = steep_new ? adx : ady;
  assign mag       = {1'b0, quo_i};

  // Minor coordinate rounded half away from zero.
  assign acc_neg = acc_q[ACC_W-1];
  assign acc_mag = acc_neg ? (~acc_q + 1'b1) : acc_q;
  assign rnd_sum = {1'b0, acc_mag} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
  assign rnd_abs = rnd_sum[ACC_W:FRAC_BITS];
  assign rnd     = acc_neg ? (~rnd_abs + 1'b1) : rnd_abs;

  // Pixel coordinates, kept wide for the bounds check.
  assign px_w = steep_q ? rnd : {{2{major_pos_q[COORD_BITS-1]}}, major_pos_q};
  assign py_w = steep_q ? {{2{major_pos_q[COORD_BITS-1]}}, major_pos_q} : rnd;
  assign px_c = {{(CMP_W-RND_W){px_w[RND_W-1]}}, px_w};
  assign py_c = {{(CMP_W-RND_W){py_w[RND_W-1]}}, py_w};
  assign fw_c = {{(CMP_W-FRAME_W){1'b0}}, frame_width_i};
  assign fh_c = {{(CMP_W-FRAME_W){1'b0}}, frame_height_i};
  assign last = (major_pos_q == major_end_q);

  assign pix_x_o           = px_w[COORD_BITS-1:0];
  assign pix_y_o           = py_w[COORD_BITS-1:0];
  assign pix_color_o       = color_q;
  assign flags_o.last      = last;
  assign flags_o.in_bounds = ~px_w[RND_W-1] & ~py_w[RND_W-1] & (px_c < fw_c) & (py_c < fh_c);
  assign active_o          = active_q;

  // Load, slope update and per-pixel advance.
  always_comb begin
    active_d     = active_q;
    steep_d      = steep_q;
    major_pos_d  = major_pos_q;
    major_end_d  = major_end_q;
    major_down_d = major_down_q;
    minor_neg_d  = minor_neg_q;
    acc_d        = acc_q;
    step_d       = step_q;
    color_d      = color_q;
    if (ctrl_i.load) begin
      active_d     = 1'b1;
      steep_d      = steep_new;
      major_pos_d  = steep_new ? y_start_i : x_start_i;
      major_end_d  = steep_new ? y_end_i : x_end_i;
      major_down_d = steep_new ? dy[DIF_W-1] : dx[DIF_W-1];
      minor_neg_d  = steep_new ? dx[DIF_W-1] : dy[DIF_W-1];
      acc_d        = {minor0[COORD_BITS-1], minor0, {FRAC_BITS{1'b0}}};
      step_d       = '0;
      color_d      = color_i;
    end else if (ctrl_i.set_slope) begin
      step_d = minor_neg_q ? (~mag + 1'b1) : mag;
    end else if (ctrl_i.step && active_q) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + (major_down_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
        acc_d       = acc_q + {{(ACC_W-STEP_W){step_q[STEP_W-1]}}, step_q};
      end
    end
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i) begin
    steep_q      <= steep_d;
    major_pos_q  <= major_pos_d;
    major_end_q  <= major_end_d;
    major_down_q <= major_down_d;
    minor_neg_q  <= minor_neg_d;
    acc_q        <= acc_d;
    step_q       <= step_d;
    color_q      <= color_d;
  end

endmodule
`default_nettype wire

>>> rtl/core/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasterizer: sequencer, frame registers and output register.
//
// Usage. Input beats arrive on the s_axis group; tuser selects the kind: a load beat
// latches both endpoints and the color, a step beat asks for the next pixel. Each
// step beat on an active line yields one m_axis beat in the cycle after acceptance; a
// step beat with no active line yields nothing. tlast marks the final pixel, after
// which the line is inactive. Frame size registers are written on the cfg channel,
// which is always ready, and should only change while the block is idle.
// Throughput: one step beat per cycle while the receiver takes pixels. A load beat
// keeps s_axis_tready low until the slope is formed: the slope is formed by one
// shared subtract and compare unit producing one quotient bit per cycle.
// Reset clears the sequencer, the output register and the active line, and sets
// both frame sizes to 600. When the receiver stalls, the pending pixel holds in
// the output register and tready stays low until it is taken.
`default_nettype none
`include "dda_line_rasterizer_unit_assert.svh"
module dda_line_rasterizer_unit
  import dda_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // Input: x_start, y_start, x_end, y_end, line_color_in (from bit 0 up).
  input  wire logic [((4*COORD_BITS+COLOR_W+7)/8)*8-1:0] s_axis_tdata,
  // Input user bits: kind.
  input  wire logic                                    s_axis_tuser,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // Output: pixel_x, pixel_y, pixel_color (from bit 0 up), zero padded.
  output logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0]    m_axis_tdata,
  // Output user bits: in_bounds.
  output logic                                         m_axis_tuser,
  output logic                                         m_axis_tlast,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // Configuration write channel.
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]                    cfg_index_i,
  input  wire logic [FRAME_W-1:0]                      cfg_data_i
);

  localparam int unsigned OUT_W = ((2*COORD_BITS+COLOR_W+7)/8)*8;

  fsm_e state_q, state_d;

  logic [FRAME_W-1:0] frame_width_q, frame_width_d;
  logic [FRAME_W-1:0] frame_height_q, frame_height_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;
  logic                  out_inb_q, out_inb_d;
  logic                  out_last_q, out_last_d;

  logic                  in_hs;
  logic                  is_step;
  walk_ctrl_t            walk_ctrl;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [FRAC_BITS:0]    div_quo;
  logic [COORD_BITS-1:0] amin, amaj;
  logic                  walk_active;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0]    pix_color;
  pix_flags_t            pix_flags;

  // Input beat decode.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign is_step       = (s_axis_tuser == KIND_STEP);

  // Sequencer: a load starts the slope division, its end writes the slope.
  always_comb begin
    state_d             = state_q;
    walk_ctrl.load      = 1'b0;
    walk_ctrl.step      = 1'b0;
    walk_ctrl.set_slope = 1'b0;
    div_start           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        walk_ctrl.step = in_hs && is_step;
        if (in_hs && !is_step) begin
          walk_ctrl.load = 1'b1;
          div_start      = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          walk_ctrl.set_slope = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame size registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_d  = cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_RESET;
      frame_height_q <= FRAME_RESET;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // Slope divider.
  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .amin_i (amin),
    .amaj_i (amaj),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Line walker.
  dda_walk #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (walk_ctrl),
    .x_start_i     (s_axis_tdata[COORD_BITS-1:0]),
    .y_start_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x_end_i       (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y_end_i       (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .color_i       (s_axis_tdata[4*COORD_BITS +: COLOR_W]),
    .frame_width_i (frame_width_q),
    .frame_height_i(frame_height_q),
    .quo_i         (div_quo),
    .amin_o        (amin),
    .amaj_o        (amaj),
    .active_o      (walk_active),
    .pix_x_o       (pix_x),
    .pix_y_o       (pix_y),
    .pix_color_o   (pix_color),
    .flags_o       (pix_flags)
  );

  // Output register: loads on a step beat of an active line, empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_inb_d   = out_inb_q;
    out_last_d  = out_last_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (walk_ctrl.step && walk_active) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_W'({pix_color, pix_y, pix_x});
      out_inb_d   = pix_flags.in_bounds;
      out_last_d  = pix_flags.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_inb_q  <= out_inb_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_inb_q;
  assign m_axis_tlast  = out_last_q;

  `DDA_ASSERT(a_done_in_div, div_done |-> (state_q == ST_DIV), "slope done outside division")
  `DDA_ASSERT(a_load_starts_div, (in_hs && !is_step) |=> (state_q == ST_DIV && div_busy), "load did not start division")
  `DDA_ASSERT(a_step_gives_beat, (in_hs && is_step && walk_active) |=> m_axis_tvalid, "active step gave no pixel")

endmodule
`default_nettype wire
